// ----- src/pdul_pkg.sv -----
// Shared types, widths and helpers for the packed depth unpacker.
package pdul_pkg;

    localparam int CODE_BITS  = 11;
    localparam int MM_BITS    = 13;
    localparam int BYTE_BITS  = 8;
    localparam int TVAL_BITS  = 16;
    localparam int ACC_BITS   = CODE_BITS + BYTE_BITS - 1;
    localparam int HELD_W     = $clog2(ACC_BITS + 1);
    localparam int TABLE_SIZE = 1 << CODE_BITS;

    // Stream packing.
    localparam int S_DATA_FIELDS = BYTE_BITS + CODE_BITS + TVAL_BITS;
    localparam int S_TDATA_W     = ((S_DATA_FIELDS + 7) / 8) * 8;
    localparam int S_TUSER_W     = 2;
    localparam int M_TDATA_W     = ((MM_BITS + CODE_BITS + 7) / 8) * 8;

    localparam int TD_BYTE_LO = 0;
    localparam int TD_IDX_LO  = TD_BYTE_LO + BYTE_BITS;
    localparam int TD_VAL_LO  = TD_IDX_LO + CODE_BITS;
    localparam int TU_MODE    = 0;
    localparam int TU_START   = 1;

    localparam logic [MM_BITS-1:0] MM_MAX = {MM_BITS{1'b1}};

    typedef enum logic {
        MODE_TABLE_WRITE = 1'b0,
        MODE_DATA        = 1'b1
    } mode_t;

    // Clamp a table value to the largest millimetre code.
    function automatic logic [MM_BITS-1:0] sat_mm(input logic [TVAL_BITS-1:0] v);
        logic [MM_BITS-1:0] r;
        if (v > TVAL_BITS'(MM_MAX)) begin
            r = MM_MAX;
        end else begin
            r = v[MM_BITS-1:0];
        end
        return r;
    endfunction

endpackage

// ----- src/pdul_ram.sv -----
// Single-port synchronous RAM with registered read data.
module pdul_ram #(
    parameter int ADDR_W = 11,
    parameter int DATA_W = 13
) (
    input  logic              aclk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [(1 << ADDR_W)];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/packed_depth_unpack_lut_top.sv -----
// Top level: packed 11-bit depth unpacker with millimetre lookup table.
// Path: a kept code reaches m_tdata through the table RAM read data register (loaded at
//   the edge that accepts its byte) and then the output register, which loads once it is
//   free.
// Throughput: one transaction per cycle, data byte or table write, while m_tready is high.
// Reset (aresetn low, synchronous): accumulator, bit count, parity and pipeline
//   valids clear; the depth table is not cleared and holds garbage until written.
module packed_depth_unpack_lut_top
    import pdul_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [7:0] data_byte, [18:8] table_index, [34:19] table_value, [39:35] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [0] mode, [1] start_of_run
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [12:0] depth_mm, [23:13] raw_code
    output logic [M_TDATA_W-1:0] m_tdata
);

    // ---------------- input field decode ----------------
    mode_t                 in_mode;
    logic                  in_start;
    logic [BYTE_BITS-1:0]  in_byte;
    logic [CODE_BITS-1:0]  in_idx;
    logic [TVAL_BITS-1:0]  in_val;

    assign in_mode  = mode_t'(s_tuser[TU_MODE]);
    assign in_start = s_tuser[TU_START];
    assign in_byte  = s_tdata[TD_BYTE_LO +: BYTE_BITS];
    assign in_idx   = s_tdata[TD_IDX_LO +: CODE_BITS];
    assign in_val   = s_tdata[TD_VAL_LO +: TVAL_BITS];

    // ---------------- pipeline handshake ----------------
    // Stage 1 waits on the RAM read; stage 2 is the output register.
    logic                 p1_valid_reg, p1_valid_next;
    logic [CODE_BITS-1:0] p1_code_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic                 out_free, p1_free, s_fire;

    assign out_free = !out_valid_reg || m_tready;
    assign p1_free  = !p1_valid_reg || out_free;
    assign s_tready = p1_free;
    assign s_fire   = s_tvalid && s_tready;

    // ---------------- bit accumulator ----------------
    logic [ACC_BITS-1:0]  acc_reg, acc_next;
    logic [HELD_W-1:0]    held_reg, held_next;
    logic                 odd_reg, odd_next;

    logic [ACC_BITS-1:0]  acc_base, acc_shift, acc_down, acc_mask;
    logic [HELD_W-1:0]    held_base, held_sum, held_left;
    logic                 odd_base, code_done, kept;
    logic [CODE_BITS-1:0] code;
    logic                 is_data;

    assign is_data   = (in_mode == MODE_DATA);

    // start_of_run realigns the run before this byte is shifted in
    assign acc_base  = in_start ? '0 : acc_reg;
    assign held_base = in_start ? '0 : held_reg;
    assign odd_base  = in_start ? 1'b0 : odd_reg;

    assign acc_shift = {acc_base[ACC_BITS-BYTE_BITS-1:0], in_byte};
    assign held_sum  = held_base + HELD_W'(BYTE_BITS);
    assign code_done = (held_sum >= HELD_W'(CODE_BITS));
    assign held_left = held_sum - HELD_W'(CODE_BITS);

    // code sits just above the bits left over; keep only the leftovers
    assign acc_down  = acc_shift >> held_left;
    assign code      = acc_down[CODE_BITS-1:0];
    assign acc_mask  = ~({ACC_BITS{1'b1}} << held_left);
    assign kept      = code_done && !odd_base;

    always_comb begin
        acc_next  = acc_reg;
        held_next = held_reg;
        odd_next  = odd_reg;
        if (s_fire && is_data) begin
            if (code_done) begin
                acc_next  = acc_shift & acc_mask;
                held_next = held_left;
                odd_next  = !odd_base;
            end else begin
                acc_next  = acc_shift;
                held_next = held_sum;
                odd_next  = odd_base;
            end
        end
    end

    // ---------------- depth table ----------------
    // A write lands at its edge, so a read in the next cycle already sees it.
    logic                 ram_we, ram_re;
    logic [CODE_BITS-1:0] ram_addr;
    logic [MM_BITS-1:0]   ram_rdata;

    assign ram_we   = s_fire && !is_data;
    assign ram_re   = s_fire && is_data && kept;
    assign ram_addr = is_data ? code : in_idx;

    pdul_ram #(
        .ADDR_W (CODE_BITS),
        .DATA_W (MM_BITS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (sat_mm(in_val)),
        .rdata (ram_rdata)
    );

    // ---------------- pipeline registers ----------------
    always_comb begin
        p1_valid_next = p1_valid_reg;
        if (p1_free) begin
            p1_valid_next = ram_re;
        end
        out_valid_next = out_valid_reg;
        if (out_free) begin
            out_valid_next = p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            held_reg      <= '0;
            odd_reg       <= 1'b0;
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            acc_reg       <= acc_next;
            held_reg      <= held_next;
            odd_reg       <= odd_next;
            p1_valid_reg  <= p1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ram_re) begin
            p1_code_reg <= code;
        end
        if (out_free && p1_valid_reg) begin
            out_data_reg <= M_TDATA_W'({p1_code_reg, ram_rdata});
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ---------------- assertions ----------------
    // Leftover bits never reach a full code.
    a_held_range: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg < HELD_W'(CODE_BITS))
        else $error("bit count reached a full code");

    // Table writes leave the unpacking state alone.
    a_write_keeps_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && !is_data) |=> ($stable(acc_reg) && $stable(held_reg) && $stable(odd_reg)))
        else $error("table write disturbed accumulator");

    // Every table lookup enters stage 1.
    a_read_tracked: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_re |=> p1_valid_reg)
        else $error("lookup lost from pipeline");

    // A blocked stage 1 keeps its entry.
    a_p1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && !out_free) |=> (p1_valid_reg && $stable(p1_code_reg)))
        else $error("stalled lookup dropped");

endmodule
